@@ src/tae_pkg.sv @@
// Package for the Thumb ALU execute block: item types, op codes and widths.
package tae_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 5;
   localparam int SHAMT_W = 8;
   localparam int IMM5_W  = 5;
   localparam int IMM8_W  = 8;

   typedef enum logic [OP_W-1:0] {
      OP_AND      = 5'd0,
      OP_EOR      = 5'd1,
      OP_LSL_REG  = 5'd2,
      OP_LSR_REG  = 5'd3,
      OP_ASR_REG  = 5'd4,
      OP_ADC      = 5'd5,
      OP_SBC      = 5'd6,
      OP_ROR_REG  = 5'd7,
      OP_TST      = 5'd8,
      OP_NEG      = 5'd9,
      OP_CMP      = 5'd10,
      OP_CMN      = 5'd11,
      OP_ORR      = 5'd12,
      OP_MUL      = 5'd13,
      OP_BIC      = 5'd14,
      OP_MVN      = 5'd15,
      OP_ADDS     = 5'd16,
      OP_SUBS     = 5'd17,
      OP_LSL_IMM  = 5'd18,
      OP_LSR_IMM  = 5'd19,
      OP_ASR_IMM  = 5'd20,
      OP_MOVS_IMM = 5'd21,
      OP_ADD      = 5'd22,
      OP_SUB      = 5'd23,
      OP_MOV      = 5'd24
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic              carry_in;
      logic              overflow_in;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              negative;
      logic              zero;
      logic              carry_flag;
      logic              overflow_out;
      logic              flags_valid;
      logic              write_result;
   } alu_rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              carry;
   } shift_res_type;

endpackage

@@ src/thumb_alu_execute_core.sv @@
// Thumb data-processing ALU: input register, single-pass logic, result register.
// An accepted item goes into the input register, then into the result register, where
// rsp_valid rises; a stall from rsp_ready can hold it in either register.
// Throughput: one item per cycle unless rsp_ready stalls; the path is the 32x32
// multiplier or 33-bit adder with the barrel shifter in parallel, then the result mux.
// Reset clears both valid bits; payload registers are not reset.
module thumb_alu_execute_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tae_pkg::alu_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tae_pkg::alu_rsp_type rsp_item
);
   import tae_pkg::*;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   alu_req_type   s1_item_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   alu_rsp_type   rsp_item_ff;
   alu_rsp_type   rsp_item_in;
   logic          out_ready;
   logic          s1_advance;

   logic [DATA_W-1:0]  add_a;
   logic [DATA_W-1:0]  add_b;
   logic               add_cin;
   logic [DATA_W:0]    add_sum;
   logic               add_v;
   logic [DATA_W-1:0]  mul_lo;
   logic [SHAMT_W-1:0] reg_amt;
   logic [SHAMT_W-1:0] imm_amt;
   logic [SHAMT_W-1:0] imm_amt_lsl;
   shift_res_type      sh;

   function automatic shift_res_type do_lsl(input logic [DATA_W-1:0] a,
                                            input logic [SHAMT_W-1:0] amt,
                                            input logic cin);
      shift_res_type       r;
      logic [2*DATA_W-1:0] w;
      w = {{DATA_W{1'b0}}, a} << amt[IMM5_W-1:0];
      if (amt == '0) begin
         r.value = a;
         r.carry = cin;
      end else if (amt < SHAMT_W'(DATA_W)) begin
         r.value = w[DATA_W-1:0];
         r.carry = w[DATA_W];
      end else begin
         r.value = '0;
         r.carry = (amt == SHAMT_W'(DATA_W)) ? a[0] : 1'b0;
      end
      return r;
   endfunction

   function automatic shift_res_type do_lsr(input logic [DATA_W-1:0] a,
                                            input logic [SHAMT_W-1:0] amt,
                                            input logic cin);
      shift_res_type   r;
      logic [DATA_W:0] w;
      w = {a, 1'b0} >> amt[IMM5_W-1:0];
      if (amt == '0) begin
         r.value = a;
         r.carry = cin;
      end else if (amt < SHAMT_W'(DATA_W)) begin
         r.value = w[DATA_W:1];
         r.carry = w[0];
      end else begin
         r.value = '0;
         r.carry = (amt == SHAMT_W'(DATA_W)) ? a[DATA_W-1] : 1'b0;
      end
      return r;
   endfunction

   function automatic shift_res_type do_asr(input logic [DATA_W-1:0] a,
                                            input logic [SHAMT_W-1:0] amt,
                                            input logic cin);
      shift_res_type          r;
      logic signed [DATA_W:0] w;
      w = $signed({a, 1'b0}) >>> amt[IMM5_W-1:0];
      if (amt == '0) begin
         r.value = a;
         r.carry = cin;
      end else if (amt < SHAMT_W'(DATA_W)) begin
         r.value = w[DATA_W:1];
         r.carry = w[0];
      end else begin
         r.value = {DATA_W{a[DATA_W-1]}};
         r.carry = a[DATA_W-1];
      end
      return r;
   endfunction

   function automatic shift_res_type do_ror(input logic [DATA_W-1:0] a,
                                            input logic [SHAMT_W-1:0] amt,
                                            input logic cin);
      shift_res_type       r;
      logic [2*DATA_W-1:0] w;
      w = {a, a} >> amt[IMM5_W-1:0];
      r.value = w[DATA_W-1:0];
      r.carry = (amt == '0) ? cin : w[DATA_W-1];
      return r;
   endfunction

   // handshake
   assign out_ready   = !rsp_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && out_ready;
   assign req_ready   = !s1_valid_ff || out_ready;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !out_ready);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // shared adder operand select
   always_comb begin
      add_a   = s1_item_ff.operand_a;
      add_b   = s1_item_ff.operand_b;
      add_cin = 1'b0;
      case (op_type'(s1_item_ff.op))
         OP_ADC: begin
            add_cin = s1_item_ff.carry_in;
         end
         OP_SBC: begin
            add_b   = ~s1_item_ff.operand_b;
            add_cin = s1_item_ff.carry_in;
         end
         OP_NEG: begin
            add_a   = '0;
            add_b   = ~s1_item_ff.operand_b;
            add_cin = 1'b1;
         end
         OP_CMP, OP_SUBS, OP_SUB: begin
            add_b   = ~s1_item_ff.operand_b;
            add_cin = 1'b1;
         end
         default: begin
            add_cin = 1'b0;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
   assign add_v   = (add_a[DATA_W-1] ^ add_sum[DATA_W-1])
                    & (add_b[DATA_W-1] ^ add_sum[DATA_W-1]);
   assign mul_lo  = s1_item_ff.operand_a * s1_item_ff.operand_b;

   assign reg_amt     = s1_item_ff.operand_b[SHAMT_W-1:0];
   assign imm_amt_lsl = SHAMT_W'(s1_item_ff.operand_b[IMM5_W-1:0]);
   assign imm_amt     = (s1_item_ff.operand_b[IMM5_W-1:0] == '0) ? SHAMT_W'(DATA_W)
                                                                   : imm_amt_lsl;

   always_comb begin
      sh = '0;
      case (op_type'(s1_item_ff.op))
         OP_LSL_REG: sh = do_lsl(s1_item_ff.operand_a, reg_amt, s1_item_ff.carry_in);
         OP_LSR_REG: sh = do_lsr(s1_item_ff.operand_a, reg_amt, s1_item_ff.carry_in);
         OP_ASR_REG: sh = do_asr(s1_item_ff.operand_a, reg_amt, s1_item_ff.carry_in);
         OP_ROR_REG: sh = do_ror(s1_item_ff.operand_a, reg_amt, s1_item_ff.carry_in);
         OP_LSL_IMM: sh = do_lsl(s1_item_ff.operand_a, imm_amt_lsl, s1_item_ff.carry_in);
         OP_LSR_IMM: sh = do_lsr(s1_item_ff.operand_a, imm_amt, s1_item_ff.carry_in);
         OP_ASR_IMM: sh = do_asr(s1_item_ff.operand_a, imm_amt, s1_item_ff.carry_in);
         default:    sh = '0;
      endcase
   end

   // result select and flags
   always_comb begin
      rsp_item_in              = '0;
      rsp_item_in.carry_flag   = s1_item_ff.carry_in;
      rsp_item_in.overflow_out = s1_item_ff.overflow_in;
      rsp_item_in.flags_valid  = 1'b1;
      rsp_item_in.write_result = 1'b1;
      case (op_type'(s1_item_ff.op))
         OP_AND: begin
            rsp_item_in.result = s1_item_ff.operand_a & s1_item_ff.operand_b;
         end
         OP_TST: begin
            rsp_item_in.result       = s1_item_ff.operand_a & s1_item_ff.operand_b;
            rsp_item_in.write_result = 1'b0;
         end
         OP_EOR: begin
            rsp_item_in.result = s1_item_ff.operand_a ^ s1_item_ff.operand_b;
         end
         OP_ORR: begin
            rsp_item_in.result = s1_item_ff.operand_a | s1_item_ff.operand_b;
         end
         OP_BIC: begin
            rsp_item_in.result = s1_item_ff.operand_a & ~s1_item_ff.operand_b;
         end
         OP_MVN: begin
            rsp_item_in.result = ~s1_item_ff.operand_b;
         end
         OP_MUL: begin
            rsp_item_in.result = mul_lo;
         end
         OP_LSL_REG, OP_LSR_REG, OP_ASR_REG, OP_ROR_REG,
         OP_LSL_IMM, OP_LSR_IMM, OP_ASR_IMM: begin
            rsp_item_in.result     = sh.value;
            rsp_item_in.carry_flag = sh.carry;
         end
         OP_ADC, OP_SBC, OP_NEG, OP_ADDS, OP_SUBS: begin
            rsp_item_in.result       = add_sum[DATA_W-1:0];
            rsp_item_in.carry_flag   = add_sum[DATA_W];
            rsp_item_in.overflow_out = add_v;
         end
         OP_CMP, OP_CMN: begin
            rsp_item_in.result       = add_sum[DATA_W-1:0];
            rsp_item_in.carry_flag   = add_sum[DATA_W];
            rsp_item_in.overflow_out = add_v;
            rsp_item_in.write_result = 1'b0;
         end
         OP_MOVS_IMM: begin
            rsp_item_in.result = DATA_W'(s1_item_ff.operand_b[IMM8_W-1:0]);
         end
         OP_ADD, OP_SUB: begin
            rsp_item_in.result      = add_sum[DATA_W-1:0];
            rsp_item_in.flags_valid = 1'b0;
         end
         OP_MOV: begin
            rsp_item_in.result      = s1_item_ff.operand_b;
            rsp_item_in.flags_valid = 1'b0;
         end
         default: begin
            rsp_item_in.result       = '0;
            rsp_item_in.flags_valid  = 1'b0;
            rsp_item_in.write_result = 1'b0;
         end
      endcase
      rsp_item_in.negative = rsp_item_in.result[DATA_W-1];
      rsp_item_in.zero     = (rsp_item_in.result == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted item did not reach the input register");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("empty input register refused an item");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("item lost between input and result registers");

   a_stall_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("stalled item in input register was dropped or changed");
`endif

endmodule
